// ===== rtl/core/beacon_tdma_node_join_fsm_macros.svh =====
// Assertion helpers for the checker file.
`ifndef BEACON_TDMA_NODE_JOIN_FSM_MACROS_SVH
`define BEACON_TDMA_NODE_JOIN_FSM_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BNJ_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define BNJ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bnj_pkg.sv =====
package bnj_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 20;

  localparam logic [CFG_INDEX_W-1:0] REG_NETWORK_ID     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BEACON_TIMEOUT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MISSED_LIMIT   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CAP_DURATION   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SLOT_DURATION  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_GUARD          = 3'd5;

  localparam logic [7:0]  RST_NETWORK_ID     = 8'd0;
  localparam logic [19:0] RST_BEACON_TIMEOUT = 20'd19000;
  localparam logic [7:0]  RST_MISSED_LIMIT   = 8'd3;
  localparam logic [15:0] RST_CAP_DURATION   = 16'd0;
  localparam logic [15:0] RST_SLOT_DURATION  = 16'd1000;
  localparam logic [9:0]  RST_GUARD          = 10'd30;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_FRAME = 1'b1;

  localparam logic [1:0] KIND_BEACON   = 2'd0;
  localparam logic [1:0] KIND_JOIN_ACK = 2'd1;
  localparam logic [1:0] KIND_OTHER    = 2'd2;
  localparam logic [1:0] KIND_RESERVED = 2'd3;

  localparam logic [1:0] ACT_NONE     = 2'd0;
  localparam logic [1:0] ACT_JOIN_REQ = 2'd1;
  localparam logic [1:0] ACT_DATA     = 2'd2;

  localparam logic [7:0]  MISS_MAX  = 8'hFF;
  localparam logic [23:0] DELAY_MAX = 24'hFF_FFFF;

  typedef enum logic [1:0] {
    MODE_SCANNING = 2'd0,
    MODE_JOINING  = 2'd1,
    MODE_RUNNING  = 2'd2,
    MODE_OFFLINE  = 2'd3
  } mode_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] frame_net;
    logic [1:0] frame_kind;
    logic [7:0] given_node_id;
    logic [7:0] given_slot;
  } item_t;

  typedef struct packed {
    logic [7:0]  network_id;
    logic [19:0] miss_timeout;
    logic [7:0]  missed_limit;
    logic [15:0] cap_length;
    logic [15:0] slot_duration_ms;
    logic [9:0]  guard_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [23:0] slot_delay_ms;
    mode_t       node_mode;
    logic [7:0]  own_id;
    logic [7:0]  own_slot;
    logic [7:0]  miss_count;
  } result_t;

endpackage

// ===== rtl/core/bnj_delay.sv =====
module bnj_delay
  import bnj_pkg::*;
(
  input  cfg_t        cfg,
  input  logic [7:0]  slot_number,
  output logic [23:0] delay
);

  logic [7:0]  slot_m1;
  logic [23:0] slot_term;
  logic [24:0] sum;

  always_comb begin
    slot_m1   = slot_number - 8'd1;
    // slot 0 has no slot term
    slot_term = (slot_number == 8'd0) ? 24'd0 :
                (24'(slot_m1) * 24'(cfg.slot_duration_ms));
    sum       = {1'b0, slot_term} + {9'd0, cfg.cap_length} + {15'd0, cfg.guard_ms};
    delay     = sum[24] ? DELAY_MAX : sum[23:0];
  end

endmodule

// ===== rtl/core/bnj_state.sv =====
module bnj_state
  import bnj_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  mode_t       mode, mode_next;
  logic [7:0]  node_ident, node_ident_next;
  logic [7:0]  slot_number, slot_number_next;
  logic [19:0] since_beacon, since_beacon_next;
  logic [7:0]  misses, misses_next;
  logic [23:0] delay;
  logic [1:0]  action;
  logic        own_net;

  bnj_delay u_delay (
    .cfg         (cfg),
    .slot_number (slot_number),
    .delay       (delay)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_SCANNING;
      node_ident   <= 8'd0;
      slot_number  <= 8'd0;
      since_beacon <= 20'd0;
      misses       <= 8'd0;
    end else if (fire) begin
      mode         <= mode_next;
      node_ident   <= node_ident_next;
      slot_number  <= slot_number_next;
      since_beacon <= since_beacon_next;
      misses       <= misses_next;
    end
  end

  always_comb begin
    mode_next         = mode;
    node_ident_next   = node_ident;
    slot_number_next  = slot_number;
    since_beacon_next = since_beacon;
    misses_next       = misses;
    action            = ACT_NONE;
    own_net           = (item.frame_net == cfg.network_id);

    if (item.opcode == OP_TICK) begin
      if (since_beacon >= cfg.miss_timeout) begin
        since_beacon_next = 20'd0;
        misses_next       = (misses == MISS_MAX) ? misses : misses + 8'd1;
        if (misses_next >= cfg.missed_limit && mode == MODE_RUNNING) begin
          mode_next = MODE_OFFLINE;
        end
      end else begin
        since_beacon_next = since_beacon + 20'd1;
      end
    end else if (own_net) begin
      case (item.frame_kind)
        KIND_BEACON: begin
          since_beacon_next = 20'd0;
          misses_next       = 8'd0;
          case (mode)
            MODE_SCANNING: mode_next = MODE_JOINING;
            MODE_OFFLINE: begin
              mode_next       = MODE_JOINING;
              node_ident_next = 8'd0;
            end
            default: mode_next = mode;
          endcase
          if (mode_next == MODE_JOINING && node_ident_next == 8'd0) begin
            action = ACT_JOIN_REQ;
          end else if (mode_next == MODE_RUNNING) begin
            action = ACT_DATA;
          end
        end
        KIND_JOIN_ACK: begin
          if (mode == MODE_JOINING) begin
            node_ident_next  = item.given_node_id;
            slot_number_next = item.given_slot;
            mode_next        = MODE_RUNNING;
          end
        end
        default: action = ACT_NONE;
      endcase
    end

    result.action        = action;
    result.slot_delay_ms = (action == ACT_DATA) ? delay : 24'd0;
    result.node_mode     = mode_next;
    result.own_id        = node_ident_next;
    result.own_slot      = slot_number_next;
    result.miss_count    = misses_next;
  end

endmodule

// ===== rtl/core/beacon_tdma_node_join_fsm.sv =====
// Pipeline: an accepted item waits in the input register, then its result is captured
// in the result register.
// Throughput: one item per cycle while result_stall does not hold the output; the node
// state updates as the result register loads, so back-to-back items see each other's effect.
// Reset (rst, synchronous): node scanning, id/slot/counters zero, registers to defaults,
// both pipeline stages empty.
module beacon_tdma_node_join_fsm
  import bnj_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic                   opcode,
  input  logic [7:0]             frame_net,
  input  logic [1:0]             frame_kind,
  input  logic [7:0]             given_node_id,
  input  logic [7:0]             given_slot,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [1:0]             action,
  output logic [23:0]            slot_delay_ms,
  output logic [1:0]             node_mode,
  output logic [7:0]             own_id,
  output logic [7:0]             own_slot,
  output logic [7:0]             miss_count
);

  cfg_t    cfg;
  item_t   item_in;
  item_t   s1_item;
  logic    s1_valid;
  logic    advance;
  logic    take;
  result_t step_result;
  result_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.network_id       <= RST_NETWORK_ID;
      cfg.miss_timeout     <= RST_BEACON_TIMEOUT;
      cfg.missed_limit     <= RST_MISSED_LIMIT;
      cfg.cap_length       <= RST_CAP_DURATION;
      cfg.slot_duration_ms <= RST_SLOT_DURATION;
      cfg.guard_ms         <= RST_GUARD;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NETWORK_ID:     cfg.network_id       <= cfg_data[7:0];
        REG_BEACON_TIMEOUT: cfg.miss_timeout     <= cfg_data[19:0];
        REG_MISSED_LIMIT:   cfg.missed_limit     <= cfg_data[7:0];
        REG_CAP_DURATION:   cfg.cap_length       <= cfg_data[15:0];
        REG_SLOT_DURATION:  cfg.slot_duration_ms <= cfg_data[15:0];
        REG_GUARD:          cfg.guard_ms         <= cfg_data[9:0];
        default:            cfg                  <= cfg;
      endcase
    end
  end

  // input register drains into the result register whenever that one is free or leaving
  assign advance    = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !advance;
  assign take       = item_valid && !item_stall;

  assign item_in.opcode        = opcode;
  assign item_in.frame_net     = frame_net;
  assign item_in.frame_kind    = frame_kind;
  assign item_in.given_node_id = given_node_id;
  assign item_in.given_slot    = given_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_item <= item_in;
    end
  end

  bnj_state u_state (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (s1_item),
    .cfg    (cfg),
    .result (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= step_result;
    end
  end

  assign action        = result.action;
  assign slot_delay_ms = result.slot_delay_ms;
  assign node_mode     = result.node_mode;
  assign own_id        = result.own_id;
  assign own_slot      = result.own_slot;
  assign miss_count    = result.miss_count;

endmodule

// ===== rtl/core/bnj_checker.sv =====
`include "beacon_tdma_node_join_fsm_macros.svh"

module bnj_checker
  import bnj_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        item_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [1:0]  action,
  input logic [23:0] slot_delay_ms,
  input logic [1:0]  node_mode,
  input logic [7:0]  own_id,
  input logic [7:0]  own_slot,
  input logic [7:0]  miss_count
);

  // held transaction keeps its payload
  `BNJ_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall,
    result_valid && $stable(action) && $stable(slot_delay_ms) && $stable(node_mode)
    && $stable(own_id) && $stable(own_slot) && $stable(miss_count),
    "result changed while stalled")

  // input only backs up behind a held result
  `BNJ_ASSERT_IMPL(a_item_stall, clk, rst, item_stall, result_valid && result_stall,
    "input stalled while output free")

  // data transmissions only come from a running node
  `BNJ_ASSERT_IMPL(a_data_running, clk, rst, result_valid && action == ACT_DATA,
    node_mode == MODE_RUNNING, "data action outside running")

  // join requests only from an unassigned joining node, never with a delay
  `BNJ_ASSERT_IMPL(a_join_req, clk, rst, result_valid && action == ACT_JOIN_REQ,
    node_mode == MODE_JOINING && own_id == 8'd0 && slot_delay_ms == 24'd0,
    "bad join request")

  // offline is only reached through a miss, and only a beacon clears misses
  `BNJ_ASSERT_IMPL(a_offline_missed, clk, rst, result_valid && node_mode == MODE_OFFLINE,
    miss_count != 8'd0, "offline without missed beacon")

endmodule

bind beacon_tdma_node_join_fsm bnj_checker u_bnj_checker (.*);
